// File: hw/rtl/stunbr_pkg.sv
// Package for the STUN binding response parser.
// Holds the protocol constants and the status codes; depends on nothing.
package stunbr_pkg;

  localparam logic [31:0] StunCookie    = 32'h2112_A442;
  localparam logic [15:0] StunBindOk    = 16'h0101;
  localparam logic [15:0] AttrXorMapped = 16'h0020;
  localparam logic [7:0]  FamilyIpv4    = 8'h01;

  localparam int unsigned PosW       = 17;
  localparam int unsigned HdrLen     = 20;
  localparam int unsigned CfgAddrW   = 4;
  localparam int unsigned CfgDataW   = 64;

  localparam logic [PosW-1:0] PosMax = '1;

  typedef enum logic [2:0] {
    ST_FOUND        = 3'd0,
    ST_BAD_TYPE     = 3'd1,
    ST_TRUNCATED    = 3'd2,
    ST_TID_MISMATCH = 3'd3,
    ST_NO_MAPPING   = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    REG_TID_HIGH = 1'b0,
    REG_TID_LOW  = 1'b1
  } reg_idx_e;

endpackage

// File: hw/rtl/stun_binding_response_parser.sv
// Result: registered; it appears in the cycle after the item carrying the last byte is accepted.
// Throughput: one datagram byte per cycle; input stalls only on a last byte while a
// previous result is still held in the output register.
// Reset: asynchronous, active low; clears the frame state, the output valid and both
// transaction id registers. The parser also returns to its reset frame state after each result.
module stun_binding_response_parser (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [stunbr_pkg::CfgAddrW-1:0]  paddr,
  input  logic [stunbr_pkg::CfgDataW-1:0]  pwdata,
  output logic [stunbr_pkg::CfgDataW-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       rx_byte_i,
  input  logic                             last_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [2:0]                       status_o,
  output logic [31:0]                      mapped_address_o,
  output logic [15:0]                      mapped_port_o
);
  import stunbr_pkg::*;

  localparam logic [PosW:0] HdrLenW = (PosW+1)'(HdrLen);

  logic [31:0]     tid_high_q;
  logic [63:0]     tid_low_q;

  logic [PosW-1:0] pos_q, pos_d;
  logic [63:0]     hdr_q, hdr_d;
  logic            tid_eq_q, tid_eq_d;
  logic [31:0]     ahs_q, ahs_d;
  logic [PosW-1:0] nas_q, nas_d;
  logic            stop_q, stop_d;
  logic            found_q, found_d;
  logic [47:0]     fe_q, fe_d;
  logic            cand_q, cand_d;
  logic            fam_q, fam_d;
  logic [PosW-1:0] bb_q, bb_d;

  logic            out_valid_q;
  logic [2:0]      status_q;
  logic [31:0]     addr_q;
  logic [15:0]     port_q;

  logic            in_acc;
  logic            cfg_wr;
  status_e         res_status;
  logic [31:0]     res_addr;
  logic [15:0]     res_port;

  logic [PosW:0]   pos_x, nas_x, bb_x, msg_end, body, body_end, pad_len, len_x;
  logic [PosW-1:0] diff;
  logic [2:0]      off;
  logic [1:0]      hi_idx;
  logic [2:0]      lo_idx;
  logic [15:0]     at, al;

  assign in_stall_o  = out_valid_q && out_stall_i && last_byte_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign mapped_address_o = addr_q;
  assign mapped_port_o    = port_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (reg_idx_e'(paddr[3])) 
      REG_TID_HIGH: prdata = {32'd0, tid_high_q};
      REG_TID_LOW:  prdata = tid_low_q;
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    pos_d    = pos_q;
    hdr_d    = hdr_q;
    tid_eq_d = tid_eq_q;
    ahs_d    = ahs_q;
    nas_d    = nas_q;
    stop_d   = stop_q;
    found_d  = found_q;
    fe_d     = fe_q;
    cand_d   = cand_q;
    fam_d    = fam_q;
    bb_d     = bb_q;

    pos_x    = {1'b0, pos_q};
    nas_x    = {1'b0, nas_q};
    bb_x     = {1'b0, bb_q};
    msg_end  = HdrLenW + {{(PosW-15){1'b0}}, hdr_q[47:32]};
    diff     = pos_q - bb_q;
    off      = diff[2:0];
    hi_idx   = ~pos_q[1:0];
    lo_idx   = 3'd3 - pos_q[2:0];
    at       = '0;
    al       = '0;
    body     = nas_x + (PosW+1)'(4);
    body_end = '0;
    pad_len  = '0;

    if (pos_q < PosW'(8)) begin
      hdr_d = {hdr_q[55:0], rx_byte_i};
    end else if (pos_q < PosW'(12)) begin
      if (tid_high_q[{hi_idx, 3'b000} +: 8] != rx_byte_i) tid_eq_d = 1'b0;
    end else if (pos_q < PosW'(HdrLen)) begin
      if (tid_low_q[{lo_idx, 3'b000} +: 8] != rx_byte_i) tid_eq_d = 1'b0;
    end else if (!stop_q && !found_q) begin
      if (cand_q && pos_x >= bb_x && pos_x < bb_x + (PosW+1)'(8)) begin
        if (off == 3'd1) fam_d = (rx_byte_i == FamilyIpv4);
        if (off >= 3'd2) fe_d = {fe_q[39:0], rx_byte_i};
        if (off == 3'd7) begin
          if (fam_q) found_d = 1'b1;
          cand_d = 1'b0;
        end
      end else if (pos_x >= nas_x && pos_x <= nas_x + (PosW+1)'(3)) begin
        if (pos_x == nas_x && body > msg_end) begin
          stop_d = 1'b1;
        end else begin
          ahs_d = {ahs_q[23:0], rx_byte_i};
          if (pos_x == nas_x + (PosW+1)'(3)) begin
            at       = ahs_d[31:16];
            al       = ahs_d[15:0];
            body_end = body + {{(PosW-15){1'b0}}, al};
            pad_len  = ({{(PosW-15){1'b0}}, al} + (PosW+1)'(3)) & ~(PosW+1)'(3);
            if (body_end > msg_end) begin
              stop_d = 1'b1;
            end else begin
              cand_d = (at == AttrXorMapped) && (al >= 16'd8);
              fam_d  = 1'b0;
              bb_d   = body[PosW-1:0];
              nas_d  = PosW'(body + pad_len);
            end
          end
        end
      end
    end

    if (pos_q != PosMax) pos_d = pos_q + PosW'(1);

    len_x    = {1'b0, pos_d};
    res_addr = '0;
    res_port = '0;
    if (pos_d < PosW'(HdrLen)) begin
      res_status = ST_TRUNCATED;
    end else if (hdr_d[63:48] != StunBindOk || hdr_d[31:0] != StunCookie) begin
      res_status = ST_BAD_TYPE;
    end else if (HdrLenW + {{(PosW-15){1'b0}}, hdr_d[47:32]} > len_x) begin
      res_status = ST_TRUNCATED;
    end else if (!tid_eq_d) begin
      res_status = ST_TID_MISMATCH;
    end else if (found_d) begin
      res_status = ST_FOUND;
      res_port   = fe_d[47:32] ^ StunCookie[31:16];
      res_addr   = fe_d[31:0] ^ StunCookie;
    end else begin
      res_status = ST_NO_MAPPING;
    end

    if (last_byte_i) begin
      pos_d    = '0;
      hdr_d    = '0;
      tid_eq_d = 1'b1;
      ahs_d    = '0;
      nas_d    = PosW'(HdrLen);
      stop_d   = 1'b0;
      found_d  = 1'b0;
      fe_d     = '0;
      cand_d   = 1'b0;
      fam_d    = 1'b0;
      bb_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tid_high_q <= '0;
      tid_low_q  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[3]))
        REG_TID_HIGH: tid_high_q <= pwdata[31:0];
        REG_TID_LOW:  tid_low_q  <= pwdata;
        default:      tid_low_q  <= tid_low_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      hdr_q    <= '0;
      tid_eq_q <= 1'b1;
      ahs_q    <= '0;
      nas_q    <= PosW'(HdrLen);
      stop_q   <= 1'b0;
      found_q  <= 1'b0;
      fe_q     <= '0;
      cand_q   <= 1'b0;
      fam_q    <= 1'b0;
      bb_q     <= '0;
    end else if (in_acc) begin
      pos_q    <= pos_d;
      hdr_q    <= hdr_d;
      tid_eq_q <= tid_eq_d;
      ahs_q    <= ahs_d;
      nas_q    <= nas_d;
      stop_q   <= stop_d;
      found_q  <= found_d;
      fe_q     <= fe_d;
      cand_q   <= cand_d;
      fam_q    <= fam_d;
      bb_q     <= bb_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && last_byte_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && last_byte_i) begin
      status_q <= res_status;
      addr_q   <= res_addr;
      port_q   <= res_port;
    end
  end

endmodule

// File: hw/rtl/stunbr_checker.sv
// Port-level checker for the STUN binding response parser, bound to the parser module.
// Depends on stunbr_pkg for the status codes.
module stunbr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             last_byte_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [2:0]                       status_o,
  input logic [31:0]                      mapped_address_o,
  input logic [15:0]                      mapped_port_o
);
  import stunbr_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(mapped_address_o) && $stable(mapped_port_o))
    else $error("held result changed");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_byte_i |=> out_valid_o)
    else $error("no result after last byte");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && last_byte_i)
    else $error("input stalled without a pending result");

  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_FOUND |-> mapped_address_o == '0 && mapped_port_o == '0)
    else $error("endpoint not cleared on failure");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_FOUND || status_o == ST_BAD_TYPE
      || status_o == ST_TRUNCATED || status_o == ST_TID_MISMATCH
      || status_o == ST_NO_MAPPING)
    else $error("status code out of range");

endmodule

bind stun_binding_response_parser stunbr_checker u_stunbr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .last_byte_i      (last_byte_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .mapped_address_o (mapped_address_o),
  .mapped_port_o    (mapped_port_o)
);

// File: bench/testbench.sv
// Self-checking bench for the STUN binding response parser: feeds datagrams byte by byte
// with random gaps and stalls, predicts each status item and compares it field by field.
// Depends on stunbr_pkg and the stun_binding_response_parser RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import stunbr_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] address;
    logic [15:0] port;
  } mapping_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          rx_byte_i = '0;
  logic                last_byte_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [2:0]          status_o;
  logic [31:0]         mapped_address_o;
  logic [15:0]         mapped_port_o;

  stun_binding_response_parser dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .mapped_address_o (mapped_address_o),
    .mapped_port_o    (mapped_port_o)
  );

  rx_item_t    byte_backlog[$];
  mapping_t    awaited_mappings[$];
  logic [7:0]  frame[$];
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned phase_bytes;
  int unsigned phase_frames;

  logic [31:0] tid_high_q = '0;
  logic [63:0] tid_low_q = '0;

  int unsigned pos_q;
  logic [63:0] header_q;
  bit          tid_ok_q;
  logic [31:0] attr_hdr_q;
  int unsigned next_attr_q;
  bit          walk_stop_q;
  bit          found_q;
  logic [47:0] endpoint_q;
  bit          cand_q;
  bit          fam_ok_q;
  int unsigned body_at_q;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void restart_parse();
    pos_q       = 0;
    header_q    = '0;
    tid_ok_q    = 1'b1;
    attr_hdr_q  = '0;
    next_attr_q = HdrLen;
    walk_stop_q = 1'b0;
    found_q     = 1'b0;
    endpoint_q  = '0;
    cand_q      = 1'b0;
    fam_ok_q    = 1'b0;
    body_at_q   = 0;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic last, output mapping_t res);
    int unsigned p;
    int unsigned msg_end;
    int unsigned al;
    int unsigned body;
    int unsigned off;
    p = pos_q;
    res = '0;
    if (p < 8) begin
      header_q = {header_q[55:0], b};
    end else if (p < 12) begin
      if (tid_high_q[8*(11-p) +: 8] != b) tid_ok_q = 1'b0;
    end else if (p < HdrLen) begin
      if (tid_low_q[8*(19-p) +: 8] != b) tid_ok_q = 1'b0;
    end else if (!walk_stop_q && !found_q) begin
      msg_end = HdrLen + header_q[47:32];
      if (cand_q && p >= body_at_q && p < body_at_q + 8) begin
        off = p - body_at_q;
        if (off == 1) fam_ok_q = (b == FamilyIpv4);
        if (off >= 2) endpoint_q = {endpoint_q[39:0], b};
        if (off == 7) begin
          if (fam_ok_q) found_q = 1'b1;
          cand_q = 1'b0;
        end
      end else if (p >= next_attr_q && p <= next_attr_q + 3) begin
        if (p == next_attr_q && next_attr_q + 4 > msg_end) begin
          walk_stop_q = 1'b1;
        end else begin
          attr_hdr_q = {attr_hdr_q[23:0], b};
          if (p == next_attr_q + 3) begin
            al = attr_hdr_q[15:0];
            body = next_attr_q + 4;
            if (body + al > msg_end) begin
              walk_stop_q = 1'b1;
            end else begin
              cand_q      = (attr_hdr_q[31:16] == AttrXorMapped) && (al >= 8);
              fam_ok_q    = 1'b0;
              body_at_q   = body;
              next_attr_q = body + ((al + 3) & ~32'd3);
            end
          end
        end
      end
    end
    if (pos_q < PosMax) pos_q++;
    if (!last) return 1'b0;
    if (pos_q < HdrLen) begin
      res.status = ST_TRUNCATED;
    end else if (header_q[63:48] != StunBindOk || header_q[31:0] != StunCookie) begin
      res.status = ST_BAD_TYPE;
    end else if (HdrLen + header_q[47:32] > pos_q) begin
      res.status = ST_TRUNCATED;
    end else if (!tid_ok_q) begin
      res.status = ST_TID_MISMATCH;
    end else if (found_q) begin
      res.status  = ST_FOUND;
      res.port    = endpoint_q[47:32] ^ StunCookie[31:16];
      res.address = endpoint_q[31:0] ^ StunCookie;
    end else begin
      res.status = ST_NO_MAPPING;
    end
    restart_parse();
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("mismatch: %s got %0h want %0h", what, got, want);
  endtask

  function automatic bit take_break();
    return ((cycle_count % 1000) >= 200) && ($urandom_range(99) < 30);
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin : drive_bytes
    rx_item_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (byte_backlog.size() != 0 && !take_break()) begin
        it = byte_backlog.pop_front();
        in_valid_i  <= 1'b1;
        rx_byte_i   <= it.data;
        last_byte_i <= it.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && take_break();
  end

  always @(posedge clk_i) begin : predict_status
    mapping_t r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (parse_byte(rx_byte_i, last_byte_i, r)) awaited_mappings.push_back(r);
    end
  end

  always @(posedge clk_i) begin : check_status
    mapping_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_mappings.size() == 0) begin
        report_mismatch("unexpected status item", 32'(status_o), 32'h0);
      end else begin
        e = awaited_mappings.pop_front();
        if (status_o != e.status) report_mismatch("status", 32'(status_o), 32'(e.status));
        if (mapped_address_o != e.address) begin
          report_mismatch("mapped_address", mapped_address_o, e.address);
        end
        if (mapped_port_o != e.port) report_mismatch("mapped_port", 32'(mapped_port_o), 32'(e.port));
      end
    end
  end

  task automatic cfg_write(reg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TID_HIGH: tid_high_q = val[31:0];
      REG_TID_LOW:  tid_low_q  = val;
      default: ;
    endcase
  endtask

  function automatic void push16(logic [15:0] v);
    frame.push_back(v[15:8]);
    frame.push_back(v[7:0]);
  endfunction

  function automatic void start_frame(bit type_ok, bit cookie_ok, bit tid_ok);
    logic [95:0] tid;
    int unsigned k;
    int unsigned j;
    frame.delete();
    push16(type_ok ? StunBindOk : 16'($urandom));
    push16(16'h0);
    push16(StunCookie[31:16]);
    push16(StunCookie[15:0]);
    if (!cookie_ok) begin
      k = $urandom_range(4, 7);
      frame[k] = frame[k] ^ (8'h1 << $urandom_range(7));
    end
    tid = {tid_high_q, tid_low_q};
    if (!tid_ok) begin
      j = $urandom_range(95);
      tid[j] = ~tid[j];
    end
    for (int i = 11; i >= 0; i--) frame.push_back(tid[8*i +: 8]);
  endfunction

  function automatic void add_attr(logic [15:0] atype, int unsigned alen, logic [7:0] fam);
    push16(atype);
    push16(16'(alen));
    for (int unsigned i = 0; i < alen; i++) frame.push_back(i == 1 ? fam : 8'($urandom));
    while (frame.size() % 4 != 0) frame.push_back(8'($urandom));
  endfunction

  function automatic void seal_length(int adj);
    int m;
    m = frame.size() - HdrLen + adj;
    if (m < 0) m = 0;
    if (m > 65535) m = 65535;
    frame[2] = m[15:8];
    frame[3] = m[7:0];
  endfunction

  function automatic void send_frame(int unsigned extra, int unsigned cut);
    rx_item_t it;
    repeat (extra) frame.push_back(8'($urandom));
    if (cut > 0) while (frame.size() > cut) void'(frame.pop_back());
    foreach (frame[i]) begin
      it.data = frame[i];
      it.last = (i == frame.size() - 1);
      byte_backlog.push_back(it);
    end
    phase_bytes += frame.size();
    phase_frames++;
  endfunction

  task automatic send_directed();
    frame.delete();
    frame.push_back(8'h00);
    send_frame(0, 0);
    frame.delete();
    frame.push_back(8'hFF);
    send_frame(0, 0);
    start_frame(1, 1, 1);
    seal_length(0);
    send_frame(0, 19);
    start_frame(1, 1, 1);
    add_attr(AttrXorMapped, 8, FamilyIpv4);
    seal_length(0);
    send_frame(0, 0);
    start_frame(0, 1, 1);
    add_attr(AttrXorMapped, 8, FamilyIpv4);
    seal_length(0);
    send_frame(0, 0);
    start_frame(1, 0, 1);
    add_attr(AttrXorMapped, 8, FamilyIpv4);
    seal_length(0);
    send_frame(0, 0);
    start_frame(1, 1, 0);
    add_attr(AttrXorMapped, 8, FamilyIpv4);
    seal_length(0);
    send_frame(0, 0);
    start_frame(1, 1, 1);
    seal_length(0);
    send_frame(0, 0);
    start_frame(1, 1, 1);
    add_attr(AttrXorMapped, 8, 8'h02);
    add_attr(AttrXorMapped, 6, FamilyIpv4);
    add_attr(AttrXorMapped, 12, FamilyIpv4);
    add_attr(AttrXorMapped, 8, FamilyIpv4);
    seal_length(0);
    send_frame(0, 0);
    start_frame(1, 1, 1);
    add_attr(16'h8028, 5, 8'h00);
    add_attr(AttrXorMapped, 8, FamilyIpv4);
    seal_length(-4);
    send_frame(0, 0);
    start_frame(1, 1, 1);
    add_attr(AttrXorMapped, 8, FamilyIpv4);
    seal_length(4);
    send_frame(0, 0);
    start_frame(1, 1, 1);
    add_attr(AttrXorMapped, 8, FamilyIpv4);
    seal_length(0);
    send_frame(10, 0);
    start_frame(1, 1, 1);
    add_attr(16'h0001, 1, 8'h00);
    add_attr(AttrXorMapped, 8, FamilyIpv4);
    seal_length(-14);
    send_frame(0, 0);
  endtask

  task automatic send_random();
    int unsigned r;
    int unsigned n_other;
    int          map_at;
    r = $urandom_range(99);
    if (r < 8) begin
      frame.delete();
      repeat ($urandom_range(1, 40)) frame.push_back(8'($urandom));
      send_frame(0, 0);
    end else if (r < 14) begin
      start_frame(1, 1, 1);
      seal_length(0);
      send_frame(0, $urandom_range(1, 19));
    end else begin
      start_frame($urandom_range(99) < 95, $urandom_range(99) < 95, $urandom_range(99) < 90);
      n_other = $urandom_range(3);
      map_at = ($urandom_range(99) < 75) ? int'($urandom_range(n_other)) : -1;
      for (int i = 0; i <= int'(n_other); i++) begin
        if (i == map_at) begin
          add_attr(AttrXorMapped, ($urandom_range(99) < 80) ? 8 : $urandom_range(8, 16),
                   ($urandom_range(99) < 90) ? FamilyIpv4 : 8'($urandom));
        end
        if (i < int'(n_other)) begin
          case ($urandom_range(2))
            0: add_attr(16'($urandom), $urandom_range(12), 8'($urandom));
            1: add_attr(AttrXorMapped, $urandom_range(7), FamilyIpv4);
            default: add_attr(AttrXorMapped, 8, 8'h02);
          endcase
        end
      end
      seal_length(($urandom_range(99) < 80) ? 0 : int'($urandom_range(16)) - 8);
      send_frame(($urandom_range(99) < 70) ? 0 : $urandom_range(1, 8),
                 ($urandom_range(99) < 90) ? 0 : $urandom_range(1, frame.size()));
    end
  endtask

  task automatic wait_idle();
    while (byte_backlog.size() != 0 || in_valid_i || awaited_mappings.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    restart_parse();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          cfg_write(REG_TID_HIGH, 64'h0);
          cfg_write(REG_TID_LOW, 64'h0);
        end
        1: begin
          cfg_write(REG_TID_HIGH, 64'h0000_0000_FFFF_FFFF);
          cfg_write(REG_TID_LOW, '1);
        end
        default: begin
          cfg_write(REG_TID_HIGH, {32'h0, 32'($urandom)});
          cfg_write(REG_TID_LOW, {32'($urandom), 32'($urandom)});
        end
      endcase
      phase_bytes = 0;
      phase_frames = 0;
      if (ph == 0) send_directed();
      while (phase_bytes < 80 || phase_frames < 3) send_random();
      wait_idle();
    end
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
